// ----- rtl/mprt_pkg.sv -----
// shared types and constants for the multichannel periodic report timer
`default_nettype none
package mprt_pkg;

   // field widths fixed by the transaction format
   localparam int unsigned NOW_W      = 32;
   localparam int unsigned IVL_W      = 30;
   localparam int unsigned ID_W       = 16;
   localparam int unsigned SEC_W      = 16;
   localparam int unsigned TICK_W     = 16;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned REPORT_W   = 4;
   localparam int unsigned RES_CNT_W  = 5;

   // channel id that addresses every channel
   localparam logic [ID_W-1:0] ALL_ID = 16'hFFFF;

   // 100 us ticks in one second
   localparam logic [13:0] TICKS_PER_SECOND = 14'd10000;

   // most reports one poll may give
   localparam logic [RES_CNT_W-1:0] RESULT_CAP = 5'd16;

   // channel count after reset
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   // default channel storage
   localparam int unsigned DEF_MAX_CHANNELS = 16;

   // transaction function codes
   localparam logic FUNC_SET  = 1'b0;
   localparam logic FUNC_POLL = 1'b1;

   // one stored channel timer
   typedef struct packed {
      logic [IVL_W-1:0] interval;
      logic [NOW_W-1:0] stamp;
   } timer_entry_type;

endpackage
`default_nettype wire

// ----- rtl/mprt_timer_ram.sv -----
// per-channel interval and stamp memory with reset valid bits
`default_nettype none
module mprt_timer_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire mprt_pkg::timer_entry_type wr_entry,
   input  wire logic                     rd_en,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output      mprt_pkg::timer_entry_type rd_entry
);
   import mprt_pkg::*;

   timer_entry_type mem [DEPTH];
   timer_entry_type rd_data_ff;
   logic [DEPTH-1:0] valid_ff;
   logic             rd_valid_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // one valid bit per entry, an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

   // a written entry is marked valid
   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written entry not marked valid");

endmodule
`default_nettype wire

// ----- rtl/mprt_due_unit.sv -----
// shared elapsed-time subtract and interval compare
`default_nettype none
module mprt_due_unit (
   input  wire logic [mprt_pkg::NOW_W-1:0] now_ticks,
   input  wire mprt_pkg::timer_entry_type  entry,
   output      logic                       due
);
   import mprt_pkg::*;

   logic [NOW_W-1:0] elapsed;

   // elapsed time wraps modulo the clock width
   always_comb begin
      elapsed = now_ticks - entry.stamp;
      due     = elapsed >= NOW_W'(entry.interval);
   end

endmodule
`default_nettype wire

// ----- rtl/multichannel_periodic_report_timer.sv -----
// top level: transaction decode, channel sequencer and report output register
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | func, channel, seconds, ticks
//  rsp     | out       | rsp_valid / rsp_ready  | report_channel, all_channels, last
//  csr     | in        | csr_valid / csr_ready  | channel_count
//
// a zero-second set ends in idle, other sets write one channel or sweep the n
// channels in use, a poll checks them and flushes (broadcast: channel 0 only;
// n zero: stays idle). the sequencer visits one channel per cycle unless
// stalled, through one memory read port and the shared due unit. req_ready
// is high only while the sequencer is idle. reset is synchronous and needs no
// clearing pass. a full output register stalls the sequencer when a further
// report is found and holds the flush step until the final report can leave.
`default_nettype none
module multichannel_periodic_report_timer #(
   parameter int unsigned MAX_CHANNELS = mprt_pkg::DEF_MAX_CHANNELS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic                          req_func,
   input  wire logic [mprt_pkg::ID_W-1:0]     req_channel,
   input  wire logic [mprt_pkg::SEC_W-1:0]    req_seconds,
   input  wire logic [mprt_pkg::TICK_W-1:0]   req_ticks,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [mprt_pkg::REPORT_W-1:0] rsp_report_channel,
   output      logic                          rsp_all_channels,
   output      logic                          rsp_last,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [mprt_pkg::COUNT_W-1:0]  csr_channel_count
);
   import mprt_pkg::*;

   localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SWEEP   = 3'd1;
   localparam logic [2:0] ST_SET_ONE = 3'd2;
   localparam logic [2:0] ST_READ    = 3'd3;
   localparam logic [2:0] ST_CHECK   = 3'd4;
   localparam logic [2:0] ST_FLUSH   = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [COUNT_W-1:0]      count_ff;
   logic [NOW_W-1:0]        now_ff, now_in;
   logic                    bcast_ff, bcast_in;
   logic [MAX_CHANNELS-1:0] enabled_ff, enabled_in;
   logic [IVL_W-1:0]        ivl_ff, ivl_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        lim_ff, lim_in;
   logic [IDX_W-1:0]        set_ch_ff, set_ch_in;
   logic [RES_CNT_W-1:0]    k_ff, k_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]        pend_ch_ff, pend_ch_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [REPORT_W-1:0]     rsp_ch_ff, rsp_ch_in;
   logic                    rsp_all_ff, rsp_all_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]        used;
   logic [CNT_W-1:0]        idx_nx;
   logic [IDX_W-1:0]        idx_lo;
   logic                    req_fire;
   logic                    slot_free;
   logic                    due_raw;
   logic                    due;
   logic                    stall;
   logic                    fin;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   timer_entry_type         wr_entry;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   timer_entry_type         rd_entry;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign idx_nx    = idx_ff + CNT_W'(1);
   assign idx_lo    = idx_ff[IDX_W-1:0];

   // channels in use, count saturated at storage depth
   assign used = (32'(count_ff) >= MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) : CNT_W'(count_ff);

   mprt_timer_ram #(
      .DEPTH  (MAX_CHANNELS),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   mprt_due_unit u_due (
      .now_ticks (now_ff),
      .entry     (rd_entry),
      .due       (due_raw)
   );

   // a channel counts as due only when enabled, or channel 0 in broadcast
   assign due   = (state_ff == ST_CHECK) && (bcast_ff || enabled_ff[idx_lo]) && due_raw;
   assign stall = due && pend_valid_ff && !slot_free;
   assign fin   = (idx_nx == lim_ff) || (due && (k_ff + RES_CNT_W'(1) == RESULT_CAP));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      bcast_in      = bcast_ff;
      enabled_in    = enabled_ff;
      ivl_in        = ivl_ff;
      idx_in        = idx_ff;
      lim_in        = lim_ff;
      set_ch_in     = set_ch_ff;
      k_in          = k_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ch_in     = rsp_ch_ff;
      rsp_all_in    = rsp_all_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_lo;
      wr_entry      = '{interval: ivl_ff, stamp: now_ff};
      rd_en         = 1'b0;
      rd_addr       = idx_lo;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in        = '0;
               k_in          = '0;
               pend_valid_in = 1'b0;
               set_ch_in     = IDX_W'(req_channel);
               ivl_in        = IVL_W'(32'(req_seconds) * 32'(TICKS_PER_SECOND));
               if (req_func == FUNC_SET) begin
                  lim_in = used;
                  if (req_seconds == '0) begin
                     bcast_in = 1'b0;
                     if (req_channel == ALL_ID) begin
                        for (int i = 0; i < MAX_CHANNELS; i++) begin
                           if (i < 32'(used)) begin
                              enabled_in[i] = 1'b0;
                           end
                        end
                     end else if (32'(req_channel) < MAX_CHANNELS) begin
                        enabled_in[IDX_W'(req_channel)] = 1'b0;
                     end
                  end else if (req_channel == ALL_ID) begin
                     bcast_in = 1'b1;
                     if (used != '0) begin
                        state_in = ST_SWEEP;
                     end
                  end else if (32'(req_channel) < MAX_CHANNELS) begin
                     state_in = ST_SET_ONE;
                  end
               end else begin
                  now_in = now_ff + NOW_W'(req_ticks);
                  if (bcast_ff) begin
                     lim_in   = CNT_W'(1);
                     state_in = ST_READ;
                  end else begin
                     lim_in = used;
                     if (used != '0) begin
                        state_in = ST_READ;
                     end
                  end
               end
            end
         end
         ST_SWEEP: begin
            // arm channels in use one per cycle
            wr_en             = 1'b1;
            enabled_in[idx_lo] = 1'b1;
            idx_in            = idx_nx;
            if (idx_nx == lim_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_SET_ONE: begin
            wr_en                 = 1'b1;
            wr_addr               = set_ch_ff;
            enabled_in[set_ch_ff] = 1'b1;
            state_in              = ST_IDLE;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // hold the found report back until the next one or the end
            if (!stall) begin
               if (due) begin
                  wr_en         = 1'b1;
                  wr_entry      = '{interval: rd_entry.interval, stamp: now_ff};
                  k_in          = k_ff + RES_CNT_W'(1);
                  pend_valid_in = 1'b1;
                  pend_ch_in    = idx_lo;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_ch_in    = REPORT_W'(pend_ch_ff);
                     rsp_all_in   = bcast_ff;
                     rsp_last_in  = 1'b0;
                  end
               end
               if (fin) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in  = idx_nx;
                  rd_en   = 1'b1;
                  rd_addr = idx_nx[IDX_W-1:0];
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ch_in     = REPORT_W'(pend_ch_ff);
               rsp_all_in    = bcast_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= COUNT_RESET;
         now_ff        <= '0;
         bcast_ff      <= 1'b0;
         enabled_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         k_ff          <= '0;
         idx_ff        <= '0;
         lim_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         bcast_ff      <= bcast_in;
         enabled_ff    <= enabled_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         k_ff          <= k_in;
         idx_ff        <= idx_in;
         lim_ff        <= lim_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_channel_count;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ivl_ff      <= ivl_in;
      set_ch_ff   <= set_ch_in;
      pend_ch_ff  <= pend_ch_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_all_ff  <= rsp_all_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_report_channel = rsp_ch_ff;
   assign rsp_all_channels   = rsp_all_ff;
   assign rsp_last           = rsp_last_ff;

   // an all-channels report always names channel 0
   a_all_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_all_ff) |-> (rsp_ch_ff == '0))
      else $error("broadcast report with nonzero channel");

   // report count never passes the per-poll cap
   a_cap: assert property (@(posedge clock) disable iff (reset)
      k_ff <= RESULT_CAP)
      else $error("report count past cap");

   // the clock holds while a poll scans
   a_now_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK || state_ff == ST_FLUSH) |=> $stable(now_ff))
      else $error("clock moved during scan");

   // the held report leaves as the final one of its poll
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && pend_valid_ff && slot_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final report not flagged last");

endmodule
`default_nettype wire
